// ----- hdl/text_line_justifier_macros.svh -----
// Assertion macros for the text line justifier.
`ifndef TEXT_LINE_JUSTIFIER_MACROS_SVH
`define TEXT_LINE_JUSTIFIER_MACROS_SVH
`ifndef SYNTHESIS
`define TLJ_ASSERT(lbl, prop) lbl: assert property (@(posedge clk) disable iff (rst) prop) \
  else $error("tlj check failed");
`define TLJ_ASSERT_NEXT(lbl, a, b) lbl: assert property (@(posedge clk) disable iff (rst) \
  a |=> b) else $error("tlj check failed");
`else
`define TLJ_ASSERT(lbl, prop)
`define TLJ_ASSERT_NEXT(lbl, a, b)
`endif
`endif

// ----- hdl/tlj_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
package tlj_pkg;

  localparam logic [7:0] SPACE_CODE = 8'd32;

  typedef struct packed {
    logic accept;
    logic clear_word;
    logic send_full;
    logic send_part;
    logic load_div;
    logic line_done;
    logic push_pad;
    logic push_char;
    logic push_gap;
    logic add_space;
    logic copy_wr;
    logic copy_end;
  } cmd_t;

  typedef struct packed {
    logic we_r;
    logic te_r;
    logic full_r;
    logic has_word;
    logic need_flush;
    logic words_nz;
    logic use_div;
    logic div_done;
    logic p_done;
    logic i_in_line;
    logic is_space;
    logic k_last;
    logic slot_free;
    logic copy_more;
  } stat_t;

endpackage
`default_nettype wire

// ----- hdl/tlj_div.sv -----
`timescale 1ns / 1ps
`default_nettype none
module tlj_div #(
  parameter int W = 6
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         start,
  input  wire logic [W-1:0] dividend,
  input  wire logic [W-1:0] divisor,
  output logic      [W-1:0] quo,
  output logic      [W-1:0] rem,
  output logic              done
);
  localparam int CW = $clog2(W + 1);

  logic [W-1:0]  dsr;
  logic [CW-1:0] cnt;
  logic          busy;
  logic [W:0]    rem_sh;
  logic          fits;

  assign rem_sh = {rem, quo[W-1]};
  assign fits   = rem_sh >= {1'b0, dsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
        quo  <= dividend;
        rem  <= '0;
        dsr  <= divisor;
      end else if (busy) begin
        rem <= fits ? W'(rem_sh - {1'b0, dsr}) : rem_sh[W-1:0];
        quo <= {quo[W-2:0], fits};
        cnt <= cnt + 1'b1;
        if (cnt == CW'(W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule
`default_nettype wire

// ----- hdl/tlj_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none
`include "text_line_justifier_macros.svh"
module tlj_ctrl
  import tlj_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  in_valid,
  output logic       in_ready,
  input  wire stat_t stat,
  output cmd_t       cmd
);
  typedef enum logic [7:0] {
    S_IDLE  = 8'b00000001,
    S_DEC   = 8'b00000010,
    S_DIV   = 8'b00000100,
    S_FETCH = 8'b00001000,
    S_PUT   = 8'b00010000,
    S_SPACE = 8'b00100000,
    S_CRD   = 8'b01000000,
    S_CWR   = 8'b10000000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else     state <= state_next;
  end

  always_comb begin
    cmd        = '0;
    in_ready   = 1'b0;
    state_next = state;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_next = S_DEC;
        end
      end
      S_DEC: begin
        if (!stat.we_r) begin
          state_next = S_IDLE;
        end else if (stat.has_word) begin
          if (stat.need_flush) begin
            cmd.send_full = 1'b1;
            state_next    = stat.use_div ? S_DIV : S_FETCH;
          end else begin
            state_next = S_SPACE;
          end
        end else begin
          cmd.clear_word = 1'b1;
          if (stat.te_r && stat.words_nz) begin
            cmd.send_part = 1'b1;
            state_next    = S_FETCH;
          end else begin
            state_next = S_IDLE;
          end
        end
      end
      S_DIV: begin
        if (stat.div_done) begin
          cmd.load_div = 1'b1;
          state_next   = S_FETCH;
        end
      end
      S_FETCH: begin
        if (stat.p_done) begin
          cmd.line_done = 1'b1;
          state_next    = stat.full_r ? S_SPACE : S_IDLE;
        end else if (stat.i_in_line) begin
          state_next = S_PUT;
        end else if (stat.slot_free) begin
          cmd.push_pad = 1'b1;
        end
      end
      S_PUT: begin
        if (stat.slot_free) begin
          if (!stat.is_space) begin
            cmd.push_char = 1'b1;
            state_next    = S_FETCH;
          end else begin
            cmd.push_gap = 1'b1;
            if (stat.k_last) state_next = S_FETCH;
          end
        end
      end
      S_SPACE: begin
        cmd.add_space = 1'b1;
        state_next    = S_CRD;
      end
      S_CRD: begin
        if (stat.copy_more) begin
          state_next = S_CWR;
        end else begin
          cmd.copy_end = 1'b1;
          if (stat.te_r) begin
            cmd.send_part = 1'b1;
            state_next    = S_FETCH;
          end else begin
            state_next = S_IDLE;
          end
        end
      end
      S_CWR: begin
        cmd.copy_wr = 1'b1;
        state_next  = S_CRD;
      end
      default: state_next = S_IDLE;
    endcase
  end

  `TLJ_ASSERT(a_state_onehot, $onehot(state))
  `TLJ_ASSERT(a_push_slot, (cmd.push_char || cmd.push_gap || cmd.push_pad) |-> stat.slot_free)
  `TLJ_ASSERT(a_ready_idle, in_ready |-> (state == S_IDLE))
endmodule
`default_nettype wire

// ----- hdl/tlj_dp.sv -----
`timescale 1ns / 1ps
`default_nettype none
`include "text_line_justifier_macros.svh"
module tlj_dp
  import tlj_pkg::*;
#(
  parameter int MAX_LINE = 32
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       cfg_we,
  input  wire logic [5:0] cfg_data,
  input  wire logic [7:0] in_char,
  input  wire logic       in_we,
  input  wire logic       in_te,
  input  wire cmd_t       cmd,
  output stat_t           stat,
  input  wire logic       out_ready,
  output logic            out_valid,
  output logic [7:0]      out_char,
  output logic            out_end,
  output logic            out_last
);
  localparam int LW = $clog2(MAX_LINE + 1);
  localparam int AW = (MAX_LINE > 1) ? $clog2(MAX_LINE) : 1;
  localparam logic [LW-1:0] MAXL = LW'(MAX_LINE);

  logic [7:0] line_mem [MAX_LINE];
  logic [7:0] word_mem [MAX_LINE];
  logic [7:0] line_rd, word_rd;

  logic [5:0]    width_reg;
  logic [LW-1:0] w_eff, wl, gaps, spare, k;
  logic [LW-1:0] word_length, line_length, words, letters;
  logic [LW-1:0] i, p, g, kc, j, base, extra;
  logic          full_r, te_r, we_r;
  logic          line_wr;
  logic [7:0]    line_wdata;
  logic          push;
  logic [7:0]    push_char;
  logic          push_end;
  logic [LW-1:0] quo, rem;
  logic          div_done, div_start;

  always_comb begin
    if (width_reg == 6'd0)              w_eff = LW'(1);
    else if (width_reg > 6'(MAX_LINE))  w_eff = MAXL;
    else                                w_eff = LW'(width_reg);
  end

  assign wl    = (word_length < w_eff) ? word_length : w_eff;
  assign gaps  = words - 1'b1;
  assign spare = (w_eff > letters) ? w_eff - letters : '0;
  assign k     = base + LW'(g < extra);

  assign stat.we_r       = we_r;
  assign stat.te_r       = te_r;
  assign stat.full_r     = full_r;
  assign stat.has_word   = wl != '0;
  assign stat.need_flush = (words != '0) &&
                           (({1'b0, line_length} + {1'b0, wl} + 1'b1) > {1'b0, w_eff});
  assign stat.words_nz   = words != '0;
  assign stat.use_div    = (words > LW'(1)) && (spare >= gaps);
  assign stat.div_done   = div_done;
  assign stat.p_done     = p >= w_eff;
  assign stat.i_in_line  = i < line_length;
  assign stat.is_space   = line_rd == SPACE_CODE;
  assign stat.k_last     = (kc + 1'b1 == k) || (p + 1'b1 == w_eff);
  assign stat.slot_free  = !out_valid || out_ready;
  assign stat.copy_more  = (j < wl) && (line_length < MAXL);

  assign div_start = cmd.send_full && stat.use_div;

  tlj_div #(.W(LW)) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (spare),
    .divisor  (gaps),
    .quo      (quo),
    .rem      (rem),
    .done     (div_done)
  );

  // storage
  assign line_wr    = cmd.copy_wr ||
                      (cmd.add_space && words != '0 && line_length < MAXL);
  assign line_wdata = cmd.copy_wr ? word_rd : SPACE_CODE;

  always_ff @(posedge clk) begin
    if (cmd.accept && in_char != SPACE_CODE && word_length < w_eff)
      word_mem[word_length[AW-1:0]] <= in_char;
    if (line_wr)
      line_mem[line_length[AW-1:0]] <= line_wdata;
    line_rd <= line_mem[i[AW-1:0]];
    word_rd <= word_mem[j[AW-1:0]];
  end

  // output slot
  assign push      = cmd.push_char || cmd.push_gap || cmd.push_pad;
  assign push_char = cmd.push_char ? line_rd : SPACE_CODE;
  assign push_end  = p + 1'b1 == w_eff;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (push) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
    if (push) begin
      out_char <= push_char;
      out_end  <= push_end;
      out_last <= push_end && (!full_r || !te_r);
    end
  end

  // counters
  always_ff @(posedge clk) begin
    if (rst) begin
      width_reg   <= 6'd32;
      word_length <= '0;
      line_length <= '0;
      words       <= '0;
      letters     <= '0;
      i           <= '0;
      p           <= '0;
      g           <= '0;
      kc          <= '0;
      j           <= '0;
      full_r      <= 1'b0;
      te_r        <= 1'b0;
      we_r        <= 1'b0;
    end else begin
      if (cfg_we) width_reg <= cfg_data;
      if (cmd.accept) begin
        te_r <= in_te;
        we_r <= in_we || in_te;
        if (in_char != SPACE_CODE && word_length < w_eff)
          word_length <= word_length + 1'b1;
      end
      if (cmd.clear_word) word_length <= '0;
      if (cmd.send_full || cmd.send_part) begin
        full_r <= cmd.send_full;
        i      <= '0;
        p      <= '0;
        g      <= '0;
        kc     <= '0;
      end
      if (cmd.line_done) begin
        line_length <= '0;
        words       <= '0;
        letters     <= '0;
        p           <= '0;
      end
      if (cmd.push_pad) p <= p + 1'b1;
      if (cmd.push_char) begin
        p <= p + 1'b1;
        i <= i + 1'b1;
      end
      if (cmd.push_gap) begin
        p <= p + 1'b1;
        if (stat.k_last) begin
          kc <= '0;
          i  <= i + 1'b1;
          g  <= g + 1'b1;
        end else begin
          kc <= kc + 1'b1;
        end
      end
      if (cmd.add_space) j <= '0;
      if (line_wr) line_length <= line_length + 1'b1;
      if (cmd.copy_wr) j <= j + 1'b1;
      if (cmd.copy_end) begin
        letters     <= letters + wl;
        words       <= words + 1'b1;
        word_length <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.send_full || cmd.send_part) begin
      base  <= LW'(1);
      extra <= '0;
    end else if (cmd.load_div) begin
      base  <= quo;
      extra <= rem;
    end
  end

  `TLJ_ASSERT(a_line_cap, line_length <= MAXL)
  `TLJ_ASSERT(a_pos_cap, p <= w_eff)
  `TLJ_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_char))
endmodule
`default_nettype wire

// ----- hdl/text_line_justifier.sv -----
// Timing: a word end that closes a line passes S_IDLE, S_DEC, S_DIV (gap divider, on a
//   justified line only), S_FETCH and S_PUT before its first output character is pushed.
// A request inside a word passes S_IDLE and S_DEC; s_axis_tready is high only in S_IDLE. Each
//   stored character goes out via S_FETCH and S_PUT; each word character is copied via S_CRD and S_CWR.
// Reset: rst synchronous, active high; empties line and word, width back to 32.
`timescale 1ns / 1ps
`default_nettype none
module text_line_justifier
  import tlj_pkg::*;
#(
  parameter int MAX_LINE = 32
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       cfg_valid,
  output logic            cfg_ready,
  input  wire logic [5:0] cfg_data,        // max_width
  input  wire logic       s_axis_tvalid,
  output logic            s_axis_tready,
  input  wire logic [7:0] s_axis_tdata,    // char_code
  input  wire logic       s_axis_tlast,    // word_end
  input  wire logic       s_axis_tuser,    // text_end
  output logic            m_axis_tvalid,
  input  wire logic       m_axis_tready,
  output logic [7:0]      m_axis_tdata,    // out_char
  output logic            m_axis_tlast,    // line_end
  output logic            m_axis_tuser     // last
);
  cmd_t  cmd;
  stat_t stat;

  assign cfg_ready = 1'b1;

  tlj_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  tlj_dp #(.MAX_LINE(MAX_LINE)) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_valid),
    .cfg_data  (cfg_data),
    .in_char   (s_axis_tdata),
    .in_we     (s_axis_tlast),
    .in_te     (s_axis_tuser),
    .cmd       (cmd),
    .stat      (stat),
    .out_ready (m_axis_tready),
    .out_valid (m_axis_tvalid),
    .out_char  (m_axis_tdata),
    .out_end   (m_axis_tlast),
    .out_last  (m_axis_tuser)
  );
endmodule
`default_nettype wire

// ----- sim/tb.sv -----
`timescale 1ns / 1ps
module tb;
  import tlj_pkg::*;

  typedef struct packed {
    logic [7:0] ch;
    logic       word_end;
    logic       text_end;
  } char_req_t;

  typedef struct packed {
    logic [7:0] ch;
    logic       line_end;
    logic       last;
  } out_char_t;

  logic clk = 0, rst = 1;
  logic cfg_valid = 0;
  logic cfg_ready;
  logic [5:0] cfg_data = 6'd32;
  logic s_axis_tvalid = 0, s_axis_tready;
  logic [7:0] s_axis_tdata = 0;
  logic s_axis_tlast = 0, s_axis_tuser = 0;
  logic m_axis_tvalid, m_axis_tready = 0;
  logic [7:0] m_axis_tdata;
  logic m_axis_tlast, m_axis_tuser;

  text_line_justifier uut (.*);

  initial begin
    forever #5 clk = ~clk;
  end

  // predictor state
  logic [5:0] width_reg;
  logic [7:0] line_buf [32];
  logic [7:0] word_buf [32];
  int line_len, word_len, word_cnt, letter_cnt;

  out_char_t expected_chars[$];
  char_req_t pending_chars[$];
  int errors = 0;
  int words_sent = 0, lines_seen = 0;
  bit quiet = 0;
  bit hold_send = 0;

  function automatic int eff_width();
    if (width_reg == 0) return 1;
    if (width_reg > 32) return 32;
    return width_reg;
  endfunction

  function automatic void emit_line(bit full);
    logic [7:0] lb [32];
    int w, gaps, base, extra, p, g, k, spare;
    out_char_t o;
    w = eff_width();
    gaps = word_cnt > 0 ? word_cnt - 1 : 0;
    base = 1; extra = 0; p = 0; g = 0;
    if (full && gaps > 0) begin
      spare = w > letter_cnt ? w - letter_cnt : 0;
      if (spare >= gaps) begin
        base = spare / gaps;
        extra = spare % gaps;
      end
    end
    for (int i = 0; i < line_len && i < 32; i++) begin
      if (line_buf[i] == SPACE_CODE) begin
        k = base + (g < extra ? 1 : 0);
        g++;
        while (k > 0 && p < w) begin
          lb[p++] = SPACE_CODE;
          k--;
        end
      end else if (p < w) begin
        lb[p++] = line_buf[i];
      end
    end
    while (p < w) lb[p++] = SPACE_CODE;
    for (int i = 0; i < w; i++) begin
      o = '{lb[i], i + 1 == w, 1'b0};
      expected_chars.insert(expected_chars.size(), o);
    end
    line_len = 0; word_cnt = 0; letter_cnt = 0;
  endfunction

  function automatic void justify_char(char_req_t r);
    int w, wl, n0;
    bit we;
    w = eff_width();
    n0 = expected_chars.size();
    we = r.word_end | r.text_end;
    if (r.ch != SPACE_CODE && word_len < w && word_len < 32)
      word_buf[word_len++] = r.ch;
    if (we) begin
      wl = word_len < w ? word_len : w;
      if (wl > 0) begin
        if (word_cnt > 0 && line_len + 1 + wl > w) emit_line(1);
        if (word_cnt > 0 && line_len < 32) line_buf[line_len++] = SPACE_CODE;
        for (int i = 0; i < wl && line_len < 32; i++) line_buf[line_len++] = word_buf[i];
        letter_cnt += wl;
        word_cnt++;
      end
      word_len = 0;
    end
    if (r.text_end && word_cnt > 0) emit_line(0);
    if (expected_chars.size() > n0)
      expected_chars[expected_chars.size() - 1].last = 1'b1;
  endfunction

  // driver
  int send_gap = 0;
  always @(posedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready)
        justify_char('{s_axis_tdata, s_axis_tlast, s_axis_tuser});
      if (!s_axis_tvalid || s_axis_tready) begin
        if (send_gap > 0) begin
          send_gap <= send_gap - 1;
          s_axis_tvalid <= 0;
        end else if (pending_chars.size() > 0 && !hold_send) begin
          char_req_t r;
          r = pending_chars.pop_front();
          s_axis_tvalid <= 1;
          s_axis_tdata <= r.ch;
          s_axis_tlast <= r.word_end;
          s_axis_tuser <= r.text_end;
          if (!quiet && $urandom_range(0, 5) == 0) send_gap <= $urandom_range(1, 8);
        end else begin
          s_axis_tvalid <= 0;
        end
      end
    end
  end

  // monitor
  int stall = 0;
  always @(posedge clk) begin
    if (!rst) begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_chars.size() == 0) begin
          $error("unexpected output char %h", m_axis_tdata);
          errors++;
        end else begin
          out_char_t e;
          e = expected_chars.pop_front();
          if (e.ch !== m_axis_tdata) begin
            $error("out_char exp %h got %h", e.ch, m_axis_tdata); errors++;
          end
          if (e.line_end !== m_axis_tlast) begin
            $error("line_end exp %b got %b", e.line_end, m_axis_tlast); errors++;
          end
          if (e.last !== m_axis_tuser) begin
            $error("last exp %b got %b", e.last, m_axis_tuser); errors++;
          end
          if (e.line_end) lines_seen++;
        end
      end
      if (stall > 0) begin
        stall <= stall - 1;
        m_axis_tready <= 0;
      end else if (!quiet && $urandom_range(0, 6) == 0) begin
        stall <= $urandom_range(0, 7);
        m_axis_tready <= 0;
      end else begin
        m_axis_tready <= 1;
      end
    end
  end

  task automatic add_word(int len, bit te);
    for (int i = 0; i < len; i++) begin
      char_req_t r;
      r.ch = 8'($urandom_range(33, 126));
      r.word_end = (i == len - 1);
      r.text_end = te && (i == len - 1);
      pending_chars.insert(pending_chars.size(), r);
    end
    words_sent++;
  endtask

  task automatic wait_drain();
    while (pending_chars.size() > 0 || s_axis_tvalid || expected_chars.size() > 0)
      @(posedge clk);
    repeat (80) @(posedge clk);
  endtask

  task automatic set_width(logic [5:0] v);
    wait_drain();
    @(posedge clk);
    cfg_valid <= 1;
    cfg_data <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 0;
    width_reg = v;
  endtask

  task automatic random_text(int n);
    int sent;
    sent = 0;
    while (sent < n) begin
      int r, len;
      char_req_t c;
      r = $urandom_range(0, 19);
      if (r == 0) begin
        c.ch = 8'($urandom); c.word_end = 1'($urandom); c.text_end = 1'($urandom);
        pending_chars.insert(pending_chars.size(), c); sent++;
      end else if (r == 1) begin
        c.ch = SPACE_CODE; c.word_end = 1; c.text_end = 0;
        pending_chars.insert(pending_chars.size(), c); sent++;
      end else begin
        len = $urandom_range(1, eff_width() + 2);
        if (len > 12 && $urandom_range(0, 3) != 0) len = $urandom_range(1, 8);
        add_word(len, r == 2);
        sent += len;
      end
    end
    add_word(1, 1);
  endtask

  initial begin
    char_req_t c;
    width_reg = 6'd32;
    line_len = 0; word_len = 0; word_cnt = 0; letter_cnt = 0;
    repeat (3) @(posedge clk);
    rst <= 0;
    // directed
    c = '{8'h00, 1'b0, 1'b0}; pending_chars.insert(pending_chars.size(), c);
    c = '{8'hFF, 1'b1, 1'b0}; pending_chars.insert(pending_chars.size(), c);
    c = '{SPACE_CODE, 1'b1, 1'b0}; pending_chars.insert(pending_chars.size(), c);
    add_word(3, 0); add_word(5, 0);
    c = '{8'h41, 1'b0, 1'b1}; pending_chars.insert(pending_chars.size(), c);
    c = '{SPACE_CODE, 1'b1, 1'b1}; pending_chars.insert(pending_chars.size(), c);
    set_width(6'd5);
    add_word(8, 0); add_word(2, 0); add_word(1, 0); add_word(2, 1);
    repeat (30) @(posedge clk);
    hold_send = 1;
    while (s_axis_tvalid || expected_chars.size() > 0) @(posedge clk);
    repeat (20) @(posedge clk);
    hold_send = 0;
    set_width(6'd20);
    add_word(6, 0); add_word(6, 0); add_word(6, 0);
    set_width(6'd3);
    add_word(2, 1);
    set_width(6'd0);
    add_word(2, 0); add_word(1, 1);
    set_width(6'd63);
    add_word(4, 1);
    // random
    set_width(6'd32); random_text(35);
    set_width(6'd12); random_text(35);
    set_width(6'd1); random_text(15);
    set_width(6'd7); random_text(35);
    quiet = 1;
    random_text(25);
    wait_drain();
    $display("covered %0d words in %0d output lines over widths 0..63", words_sent, lines_seen);
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("[FAIL] regression broken");
    $finish;
  end
endmodule
